// ===== sv/safcd_pkg.sv =====
// Shared types and constants for the set-associative FIFO cache directory.
// Holds the controller/datapath command and status structs and the fixed field widths.
// No dependencies.
package safcd_pkg;

    localparam int KEY_W     = 32;
    localparam int BASE_W    = 48;
    localparam int SIZE_W    = 8;
    localparam int FADDR_W   = 49;
    localparam int CNT_W     = 32;
    localparam int SET_NUM_W = 11;
    localparam int WAY_NUM_W = 4;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 64;

    localparam logic [SIZE_W-1:0] ENTRY_SIZE_RESET = 8'd16;
    localparam logic [CNT_W-1:0]  CNT_MAX          = '1;

    // Operation carried by a request beat.
    typedef enum logic {
        OP_LOOKUP     = 1'b0,
        OP_INVALIDATE = 1'b1
    } dir_op_t;

    // Register indexes; the registers sit 8 bytes apart.
    typedef enum logic {
        REG_DATA_BASE  = 1'b0,
        REG_ENTRY_SIZE = 1'b1
    } dir_reg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // latch the request beat, start the set computation
        logic rd;         // read the key row and meta row of the set
        logic cmp;        // compare, write back on a miss, update counters
        logic clr;        // clear one meta row and advance the clear address
        logic load_now;   // load the response from the compare result
        logic load_hold;  // load the response from the held compare result
        logic load_inv;   // load the response of an invalidate
    } dir_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic set_valid;  // the set index of the latched key is ready
        logic clr_last;   // the clear address points at the last set
        logic rsp_free;   // the response register can take a result this cycle
    } dir_sts_t;

endpackage

// ===== sv/safcd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module safcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/safcd_ctrl.sv =====
// Controller state machine of the cache directory.
// Depends on safcd_pkg for the command and status structs.
module safcd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                operation,
    output logic                req_ready,
    output safcd_pkg::dir_cmd_t cmd,
    input  safcd_pkg::dir_sts_t sts
);
    import safcd_pkg::*;

    typedef enum logic [2:0] {
        ST_CLR_INIT,
        ST_IDLE,
        ST_SET,
        ST_CMP,
        ST_EMIT,
        ST_CLR_INV,
        ST_INV_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLR_INIT:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (operation == OP_INVALIDATE) ? ST_CLR_INV : ST_SET;
                end
            end
            ST_SET:
            begin
                if (sts.set_valid)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.cmp = 1'b1;
                if (sts.rsp_free)
                begin
                    cmd.load_now = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.rsp_free)
                begin
                    cmd.load_hold = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_CLR_INV:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    if (sts.rsp_free)
                    begin
                        cmd.load_inv = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_INV_EMIT;
                    end
                end
            end
            ST_INV_EMIT:
            begin
                if (sts.rsp_free)
                begin
                    cmd.load_inv = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLR_INIT;
            end
        endcase
    end

endmodule

// ===== sv/safcd_dp.sv =====
// Datapath of the cache directory: set index, tag and meta RAMs, compare,
// replacement, fill address, counters and the response register.
// Depends on safcd_pkg and safcd_ram.
module safcd_dp #(
    parameter int SETS = 2048,
    parameter int WAYS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  safcd_pkg::dir_cmd_t                    cmd,
    output safcd_pkg::dir_sts_t                    sts,
    input  logic [safcd_pkg::KEY_W-1:0]            record_key,
    input  logic [safcd_pkg::BASE_W-1:0]           data_base,
    input  logic [safcd_pkg::SIZE_W-1:0]           entry_size,
    input  logic                                   rsp_ready,
    output logic                                   rsp_valid,
    output logic                                   hit,
    output logic                                   fill_needed,
    output logic [safcd_pkg::SET_NUM_W-1:0]        set_number,
    output logic [safcd_pkg::WAY_NUM_W-1:0]        way_number,
    output logic [safcd_pkg::FADDR_W-1:0]          fill_address,
    output logic [safcd_pkg::CNT_W-1:0]            access_total,
    output logic [safcd_pkg::CNT_W-1:0]            hit_total
);
    import safcd_pkg::*;

    localparam int SET_W    = $clog2(SETS);
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W    = WAYS * KEY_W;
    localparam int META_W   = WAYS + WAY_W;
    localparam int PROD_W   = KEY_W + SIZE_W;
    localparam bit SET_POW2 = ((SETS & (SETS - 1)) == 0);

    logic [KEY_W-1:0]   key_reg;
    logic [SET_W-1:0]   set_cur;
    logic               set_valid;
    logic [SET_W-1:0]   set_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SET_W-1:0]   clr_addr_reg;

    logic [ROW_W-1:0]   key_row;
    logic [ROW_W-1:0]   key_wrow;
    logic               key_we;
    logic [META_W-1:0]  meta_row;
    logic [META_W-1:0]  meta_wrow;
    logic [SET_W-1:0]   meta_waddr;
    logic               meta_we;

    logic [WAYS-1:0]    valid_row;
    logic [WAY_W-1:0]   ptr_row;
    logic [WAYS-1:0]    match;
    logic               hit_c;
    logic [WAY_W-1:0]   way_hit;
    logic [WAY_W-1:0]   way_c;
    logic [WAY_W-1:0]   ptr_next;
    logic [WAYS-1:0]    valid_new;
    logic [FADDR_W-1:0] fill_c;

    logic [CNT_W-1:0]   lookup_reg;
    logic [CNT_W-1:0]   hitcnt_reg;
    logic [CNT_W-1:0]   lookup_next;
    logic [CNT_W-1:0]   hitcnt_next;

    logic               hold_hit_reg;
    logic [WAY_W-1:0]   hold_way_reg;
    logic [FADDR_W-1:0] hold_fill_reg;

    logic               rsp_valid_reg;

    // Set index: a mask for a power-of-two set count, otherwise a remainder
    // by reciprocal multiplication in three registered steps: the high half
    // of key times the magic constant, the corrected quotient, and the key
    // minus quotient times SETS.
    generate
        if (SET_POW2)
        begin : g_mask
            assign set_cur   = key_reg[SET_W-1:0];
            assign set_valid = 1'b1;
        end
        else
        begin : g_rem
            localparam int SHIFT = SET_W - 1;
            localparam longint unsigned MAGIC_L =
                ((((64'd1 << SET_W) - 64'(SETS)) << 32) / 64'(SETS)) + 64'd1;
            localparam logic [KEY_W-1:0] MAGIC = KEY_W'(MAGIC_L);

            logic [2*KEY_W-1:0] mprod;
            logic [KEY_W-1:0]   sum;
            logic [KEY_W-1:0]   qd;
            logic [KEY_W-1:0]   t_reg;
            logic [KEY_W-1:0]   q_reg;
            logic [SET_W-1:0]   rem_reg;
            logic [1:0]         bits_reg;

            assign mprod = (2*KEY_W)'(key_reg) * (2*KEY_W)'(MAGIC);
            assign sum   = t_reg + ((key_reg - t_reg) >> 1);
            assign qd    = q_reg * KEY_W'(SETS);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    bits_reg <= '0;
                end
                else if (cmd.accept)
                begin
                    bits_reg <= 2'd3;
                end
                else if (bits_reg != '0)
                begin
                    bits_reg <= bits_reg - 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                t_reg   <= mprod[2*KEY_W-1:KEY_W];
                q_reg   <= sum >> SHIFT;
                rem_reg <= SET_W'(key_reg - qd);
            end

            assign set_cur   = rem_reg;
            assign set_valid = (bits_reg == '0);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg <= record_key;
        end
        if (cmd.rd)
        begin
            set_reg <= set_cur;
        end
        prod_reg <= key_reg * entry_size;
        if (cmd.cmp)
        begin
            hold_hit_reg  <= hit_c;
            hold_way_reg  <= way_c;
            hold_fill_reg <= fill_c;
        end
    end

    safcd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (set_reg),
        .wdata (key_wrow),
        .re    (cmd.rd),
        .raddr (set_cur),
        .rdata (key_row)
    );

    safcd_ram #(
        .WIDTH (META_W),
        .DEPTH (SETS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wrow),
        .re    (cmd.rd),
        .raddr (set_cur),
        .rdata (meta_row)
    );

    assign valid_row = meta_row[WAYS-1:0];
    assign ptr_row   = meta_row[META_W-1:WAYS];

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            match[w]     = valid_row[w] && (key_row[w*KEY_W +: KEY_W] == key_reg);
            valid_new[w] = valid_row[w] | (ptr_row == WAY_W'(w));
            if (ptr_row == WAY_W'(w))
            begin
                key_wrow[w*KEY_W +: KEY_W] = key_reg;
            end
            else
            begin
                key_wrow[w*KEY_W +: KEY_W] = key_row[w*KEY_W +: KEY_W];
            end
        end
        way_hit = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                way_hit = WAY_W'(w);
            end
        end
    end

    assign hit_c    = |match;
    assign way_c    = hit_c ? way_hit : ptr_row;
    assign ptr_next = (ptr_row == WAY_W'(WAYS - 1)) ? '0 : ptr_row + 1'b1;
    assign fill_c   = hit_c ? '0
                            : ({1'b0, data_base} + FADDR_W'(prod_reg));

    assign key_we     = cmd.cmp && !hit_c;
    assign meta_we    = cmd.clr || (cmd.cmp && !hit_c);
    assign meta_waddr = cmd.clr ? clr_addr_reg : set_reg;
    assign meta_wrow  = cmd.clr ? '0 : {ptr_next, valid_new};

    assign lookup_next = (lookup_reg == CNT_MAX) ? lookup_reg : lookup_reg + 1'b1;
    assign hitcnt_next = (hit_c && (hitcnt_reg != CNT_MAX)) ? hitcnt_reg + 1'b1
                                                           : hitcnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookup_reg   <= '0;
            hitcnt_reg   <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.cmp)
            begin
                lookup_reg <= lookup_next;
                hitcnt_reg <= hitcnt_next;
            end
            if (cmd.clr)
            begin
                clr_addr_reg <= (clr_addr_reg == SET_W'(SETS - 1)) ? '0
                                                                   : clr_addr_reg + 1'b1;
            end
        end
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load_now || cmd.load_hold || cmd.load_inv)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_now)
        begin
            hit          <= hit_c;
            fill_needed  <= !hit_c;
            set_number   <= SET_NUM_W'(set_reg);
            way_number   <= WAY_NUM_W'(way_c);
            fill_address <= fill_c;
            access_total <= lookup_next;
            hit_total    <= hitcnt_next;
        end
        else if (cmd.load_hold)
        begin
            hit          <= hold_hit_reg;
            fill_needed  <= !hold_hit_reg;
            set_number   <= SET_NUM_W'(set_reg);
            way_number   <= WAY_NUM_W'(hold_way_reg);
            fill_address <= hold_fill_reg;
            access_total <= lookup_reg;
            hit_total    <= hitcnt_reg;
        end
        else if (cmd.load_inv)
        begin
            hit          <= 1'b0;
            fill_needed  <= 1'b0;
            set_number   <= '0;
            way_number   <= '0;
            fill_address <= '0;
            access_total <= lookup_reg;
            hit_total    <= hitcnt_reg;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign sts.set_valid = set_valid;
    assign sts.clr_last  = (clr_addr_reg == SET_W'(SETS - 1));
    assign sts.rsp_free  = !rsp_valid_reg || rsp_ready;

endmodule

// ===== sv/set_assoc_fifo_cache_directory.sv =====
// Top level of the set-associative cache directory with FIFO replacement.
// Depends on safcd_pkg, safcd_ctrl, safcd_dp and safcd_ram.
//
//   Channel   Direction  Handshake                      Beat contents
//   request   in         req_valid / req_ready          operation, record_key
//   response  out        rsp_valid / rsp_ready          hit .. hit_total (7 fields)
//   config    in         psel, penable, pwrite, pready  data_base @ 0x0, entry_size @ 0x8
//
// A lookup passes through accept, RAM read, and compare and write back before its
// response is loaded when SETS is a power of two; otherwise the set index comes from a
// reciprocal-multiply remainder unit whose registered steps lie between the accept and
// the RAM read. One lookup is in flight at a time: req_ready stays low until its result
// is loaded into the response register. An invalidate clears one set per cycle in the
// meta RAM, walking every set, and then answers. After reset the same clearing pass runs
// over every set with req_ready low.
// A waiting response does not block the next request; a second result waits
// in the datapath until the response register frees up.
module set_assoc_fifo_cache_directory #(
    parameter int SETS = 2048,
    parameter int WAYS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [safcd_pkg::PADDR_W-1:0]          paddr,
    input  logic [safcd_pkg::PDATA_W-1:0]          pwdata,
    output logic [safcd_pkg::PDATA_W-1:0]          prdata,
    output logic                                   pready,
    // Request channel
    input  logic                                   req_valid,
    output logic                                   req_ready,
    input  logic                                   operation,
    input  logic [safcd_pkg::KEY_W-1:0]            record_key,
    // Response channel
    output logic                                   rsp_valid,
    input  logic                                   rsp_ready,
    output logic                                   hit,
    output logic                                   fill_needed,
    output logic [safcd_pkg::SET_NUM_W-1:0]        set_number,
    output logic [safcd_pkg::WAY_NUM_W-1:0]        way_number,
    output logic [safcd_pkg::FADDR_W-1:0]          fill_address,
    output logic [safcd_pkg::CNT_W-1:0]            access_total,
    output logic [safcd_pkg::CNT_W-1:0]            hit_total
);
    import safcd_pkg::*;

    logic [BASE_W-1:0] data_base_reg;
    logic [SIZE_W-1:0] entry_size_reg;
    logic              cfg_write;
    logic              reg_sel;

    dir_cmd_t cmd;
    dir_sts_t sts;

    // Registers are 64-bit aligned; the decode looks only at the register
    // select bit of the address.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[3];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_base_reg  <= '0;
            entry_size_reg <= ENTRY_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_sel == REG_DATA_BASE)
            begin
                data_base_reg <= pwdata[BASE_W-1:0];
            end
            else
            begin
                entry_size_reg <= pwdata[SIZE_W-1:0];
            end
        end
    end

    assign prdata = (reg_sel == REG_ENTRY_SIZE) ? PDATA_W'(entry_size_reg)
                                                : PDATA_W'(data_base_reg);

    // The controller sequences the lookup, the clearing pass and the
    // response hand-off; the datapath holds all storage and arithmetic.
    safcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .operation (operation),
        .req_ready (req_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    safcd_dp #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .record_key   (record_key),
        .data_base    (data_base_reg),
        .entry_size   (entry_size_reg),
        .rsp_ready    (rsp_ready),
        .rsp_valid    (rsp_valid),
        .hit          (hit),
        .fill_needed  (fill_needed),
        .set_number   (set_number),
        .way_number   (way_number),
        .fill_address (fill_address),
        .access_total (access_total),
        .hit_total    (hit_total)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the set-associative FIFO cache directory.
// Depends on safcd_pkg and set_assoc_fifo_cache_directory. It drives lookups, invalidates
// and register writes, stalls both channels at random, and checks every response beat.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import safcd_pkg::*;

    // The geometry matches the default parameters of the directory.
    localparam int NUM_SETS       = 2048;
    localparam int NUM_WAYS       = 16;
    localparam int TAG_W          = KEY_W - SET_NUM_W;
    localparam int REG_STRIDE     = 8;
    // An invalidate and the clearing pass after reset each walk every set of the directory,
    // so the idle limit is a few times the longer of those plus the longest stalls.
    localparam int WATCHDOG_LIMIT = 12000;
    // Settling margin that wait_idle adds after the last predicted response has come back.
    localparam int SETTLE_CYCLES  = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int HOT_SETS       = 4;
    localparam int HOT_TAGS       = 20;

    // One response beat, in the order of the response ports.
    typedef struct packed {
        logic                 hit;
        logic                 fill_needed;
        logic [SET_NUM_W-1:0] set_num;
        logic [WAY_NUM_W-1:0] way_num;
        logic [FADDR_W-1:0]   fill_addr;
        logic [CNT_W-1:0]     access_cnt;
        logic [CNT_W-1:0]     hit_cnt;
    } dir_beat_t;

    // Shadow copy of the tag directory. Each accepted request beat is run through it at once,
    // and the response it would give waits in a queue until the matching response beat shows up.
    class directory_shadow;
        logic [KEY_W-1:0]  tag_key     [NUM_SETS*NUM_WAYS];
        bit                line_valid  [NUM_SETS*NUM_WAYS];
        int unsigned       next_victim [NUM_SETS];
        logic [CNT_W-1:0]  lookups;
        logic [CNT_W-1:0]  hits;
        logic [BASE_W-1:0] base_addr;
        logic [SIZE_W-1:0] record_bytes;
        dir_beat_t         awaited[$];
        int                failures;

        function new();
            clear_lines();
            lookups      = '0;
            hits         = '0;
            base_addr    = '0;
            record_bytes = ENTRY_SIZE_RESET;
            failures     = 0;
        endfunction

        // Stored keys are left alone; the valid bits keep them from ever being compared.
        function void clear_lines();
            foreach (line_valid[i])
                line_valid[i] = 1'b0;
            foreach (next_victim[s])
                next_victim[s] = 0;
        endfunction

        function void set_register(dir_reg_t idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_DATA_BASE:  base_addr    = value[BASE_W-1:0];
                REG_ENTRY_SIZE: record_bytes = value[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(dir_op_t op, logic [KEY_W-1:0] key);
            dir_beat_t   beat;
            int unsigned set_idx;
            int unsigned slot;
            bit          found;
            logic [63:0] byte_addr;
            beat = '0;
            if (op == OP_INVALIDATE)
            begin
                // An invalidate reports the counters untouched and zeros everywhere else.
                clear_lines();
            end
            else
            begin
                set_idx = key % NUM_SETS;
                found   = 1'b0;
                slot    = 0;
                if (lookups != CNT_MAX)
                    lookups = lookups + 1'b1;
                // The lowest matching way wins, though a key should never sit in two ways.
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    if (!found && line_valid[set_idx*NUM_WAYS + w]
                        && tag_key[set_idx*NUM_WAYS + w] == key)
                    begin
                        found = 1'b1;
                        slot  = w;
                    end
                end
                if (found)
                begin
                    if (hits != CNT_MAX)
                        hits = hits + 1'b1;
                end
                else
                begin
                    // Round-robin victim: take the pointed way, then move the pointer on.
                    slot                                = next_victim[set_idx];
                    next_victim[set_idx]                = (slot + 1) % NUM_WAYS;
                    tag_key[set_idx*NUM_WAYS + slot]    = key;
                    line_valid[set_idx*NUM_WAYS + slot] = 1'b1;
                    byte_addr = {16'b0, base_addr} + 64'(key) * 64'(record_bytes);
                    beat.fill_addr = byte_addr[FADDR_W-1:0];
                end
                beat.hit         = found;
                beat.fill_needed = !found;
                beat.set_num     = SET_NUM_W'(set_idx);
                beat.way_num     = WAY_NUM_W'(slot);
            end
            beat.access_cnt = lookups;
            beat.hit_cnt    = hits;
            awaited.push_back(beat);
        endfunction

        function void check_response(dir_beat_t got);
            dir_beat_t want;
            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected response beat: hit %b fill %b set %0d way %0d addr %h",
                             got.hit, got.fill_needed, got.set_num, got.way_num, got.fill_addr);
                return;
            end
            want = awaited.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                begin
                    $display("response mismatch (expected / actual):");
                    $display("  hit %b / %b  fill_needed %b / %b  set %0d / %0d  way %0d / %0d",
                             want.hit, got.hit, want.fill_needed, got.fill_needed,
                             want.set_num, got.set_num, want.way_num, got.way_num);
                    $display("  fill_address %h / %h", want.fill_addr, got.fill_addr);
                    $display("  access_total %0d / %0d  hit_total %0d / %0d",
                             want.access_cnt, got.access_cnt, want.hit_cnt, got.hit_cnt);
                end
            end
        endfunction
    endclass

    // Every input of the directory starts at a known value.
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [PADDR_W-1:0]   paddr       = '0;
    logic [PDATA_W-1:0]   pwdata      = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 req_valid   = 1'b0;
    logic                 req_ready;
    logic                 operation   = 1'b0;
    logic [KEY_W-1:0]     record_key  = '0;
    logic                 rsp_valid;
    logic                 rsp_ready   = 1'b0;
    logic                 hit;
    logic                 fill_needed;
    logic [SET_NUM_W-1:0] set_number;
    logic [WAY_NUM_W-1:0] way_number;
    logic [FADDR_W-1:0]   fill_address;
    logic [CNT_W-1:0]     access_total;
    logic [CNT_W-1:0]     hit_total;

    directory_shadow shadow;

    // When a side is eager it never idles, which gives stretches of back-to-back beats.
    bit          sender_eager   = 1'b0;
    bit          receiver_eager = 1'b0;
    int          idle_cycles    = 0;

    // Each random phase works on a few hot sets and a pool of tags a little larger than the
    // number of ways, so lookups both hit and push the round-robin pointer around the set.
    int unsigned      hot_set [HOT_SETS];
    logic [TAG_W-1:0] hot_tag [HOT_TAGS];

    set_assoc_fifo_cache_directory u_dut (.*);

    always #4 clk = ~clk;

    // The watchdog ends the run once no beat and no register write has been accepted
    // for too long; a hung handshake or a lost response shows up here.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Response side: stall a random number of cycles, then hold ready high until a beat
    // arrives, and check it against the oldest waiting prediction.
    initial
    begin : response_sink
        dir_beat_t got;
        int        stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = receiver_eager ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 29) == 0)
                receiver_eager = !receiver_eager;
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            got = {hit, fill_needed, set_number, way_number, fill_address,
                   access_total, hit_total};
            shadow.check_response(got);
        end
    end

    // Sends one request beat. Valid is lowered only when a gap is drawn, so a beat that
    // follows straight on keeps valid high without a second assignment in the same step.
    // The task is entered and left right after a rising edge.
    task automatic send_beat(input dir_op_t op, input logic [KEY_W-1:0] key);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 29) == 0)
            sender_eager = !sender_eager;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        operation  <= op;
        record_key <= key;
        do
            @(posedge clk);
        while (!req_ready);
        shadow.note_request(op, key);
    endtask

    // Lowers valid and waits until every predicted response has come back, plus a settling
    // margin, so that the directory is idle before a register changes.
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (shadow.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: a setup phase, then an access phase that completes on pready.
    task automatic write_register(input dir_reg_t idx, input logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * REG_STRIDE);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow.set_register(idx, value);
    endtask

    task automatic reconfigure(input logic [BASE_W-1:0] base, input logic [SIZE_W-1:0] size);
        wait_idle();
        write_register(REG_DATA_BASE, PDATA_W'(base));
        write_register(REG_ENTRY_SIZE, PDATA_W'(size));
    endtask

    // Picks the hot sets and tags for the next random phase. One hot set always sits at
    // an end of the set range.
    task automatic pick_working_set();
        hot_set[0] = $urandom_range(0, 1) ? 0 : NUM_SETS - 1;
        for (int s = 1; s < HOT_SETS; s++)
            hot_set[s] = $urandom_range(0, NUM_SETS - 1);
        foreach (hot_tag[t])
            hot_tag[t] = TAG_W'($urandom);
    endtask

    // Random traffic: mostly lookups into the hot sets, some fully random keys, and
    // now and then an invalidate carrying a random key that the directory ignores.
    task automatic send_random(input int count);
        int               roll;
        logic [KEY_W-1:0] key;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            key  = $urandom;
            if (roll < 2)
            begin
                send_beat(OP_INVALIDATE, key);
            end
            else
            begin
                if (roll < 75)
                    key = {hot_tag[$urandom_range(0, HOT_TAGS - 1)],
                           SET_NUM_W'(hot_set[$urandom_range(0, HOT_SETS - 1)])};
                send_beat(OP_LOOKUP, key);
            end
        end
    endtask

    initial
    begin : stimulus
        shadow = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset register values. A key is first a miss and then
        // a hit; the lowest and highest keys land in the first and last sets; a second key
        // in set zero takes the next way; an invalidate sends the pointer back to way zero.
        send_beat(OP_LOOKUP, 32'h0000_0000);
        send_beat(OP_LOOKUP, 32'h0000_0000);
        send_beat(OP_LOOKUP, 32'hFFFF_FFFF);
        send_beat(OP_LOOKUP, 32'hFFFF_FFFF);
        send_beat(OP_LOOKUP, 32'h0000_0800);
        send_beat(OP_LOOKUP, 32'h0000_0000);
        send_beat(OP_LOOKUP, 32'h0000_0800);
        send_beat(OP_INVALIDATE, 32'h0000_0000);
        send_beat(OP_LOOKUP, 32'h0000_0000);
        send_beat(OP_INVALIDATE, 32'hFFFF_FFFF);
        send_beat(OP_LOOKUP, 32'h0000_07FF);
        send_beat(OP_LOOKUP, 32'h8000_0000);

        // Largest base and record size: the all-ones key gives the largest fill address,
        // and key zero gives the base itself.
        reconfigure({BASE_W{1'b1}}, {SIZE_W{1'b1}});
        send_beat(OP_LOOKUP, 32'hFFFF_FFFF);
        send_beat(OP_LOOKUP, 32'h0000_0000);
        send_beat(OP_LOOKUP, 32'hFFFF_FFFF);
        send_beat(OP_LOOKUP, 32'h5555_5555);
        send_beat(OP_LOOKUP, 32'hAAAA_AAAA);
        pick_working_set();
        send_random(150);

        // Smallest base and a record size of one.
        reconfigure('0, SIZE_W'(1));
        pick_working_set();
        send_random(150);

        // Random register values for the remaining phases.
        for (int phase = 0; phase < 3; phase++)
        begin
            reconfigure(BASE_W'({$urandom, $urandom}), SIZE_W'($urandom_range(1, 255)));
            pick_working_set();
            send_random(150);
        end

        wait_idle();
        if (shadow.failures == 0 && shadow.awaited.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== set_assoc_fifo_cache_directory.f =====
sv/safcd_pkg.sv
sv/safcd_ram.sv
sv/safcd_ctrl.sv
sv/safcd_dp.sv
sv/set_assoc_fifo_cache_directory.sv
tb/tb.sv
